// ===== src/prime_trial_division_unit_defines.svh =====
// Assertion macros shared by the prime trial division RTL.
// Both expect clk and rst_n in the enclosing module.
`ifndef PRIME_TRIAL_DIVISION_UNIT_DEFINES_SVH
`define PRIME_TRIAL_DIVISION_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PTD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ptd_pkg.sv =====
package ptd_pkg;

    // trial divisor constants
    localparam int FIRST_DIVISOR = 5;
    localparam int DIVISOR_STEP  = 6;
    localparam int PAIR_OFFSET   = 2;

    localparam int UPC_W = 3;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t STEP_IDLE    = 3'd0;
    localparam upc_t STEP_ENTRY   = 3'd1;
    localparam upc_t STEP_MOD3    = 3'd2;
    localparam upc_t STEP_DIV_I   = 3'd3;
    localparam upc_t STEP_WAIT_I  = 3'd4;
    localparam upc_t STEP_DIV_I2  = 3'd5;
    localparam upc_t STEP_WAIT_I2 = 3'd6;
    localparam upc_t STEP_EMIT    = 3'd7;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN_BEAT,
        COND_OUT_BEAT,
        COND_DIV_DONE
    } cond_t;

    typedef enum logic [0:0] {
        DSEL_I,
        DSEL_I_PLUS2
    } dsel_t;

    typedef enum logic [2:0] {
        TEST_NONE,
        TEST_ENTRY,
        TEST_MOD3,
        TEST_REM,
        TEST_BOUND_REM
    } test_t;

    typedef enum logic [1:0] {
        IOP_KEEP,
        IOP_INIT,
        IOP_STEP
    } iop_t;

    typedef struct packed {
        logic  accept;
        logic  emit;
        logic  start_div;
        dsel_t dsel;
        cond_t cond;
        test_t test;
        iop_t  iop;
        upc_t  next;
    } ctl_word_t;

    // Control store. A step holds until its condition is met, then runs its
    // test and goes to next (or to STEP_EMIT if the test settles the answer).
    function automatic ctl_word_t ptd_ucode(input upc_t upc);
        ctl_word_t w;
        begin
            w = '{accept: 1'b0, emit: 1'b0, start_div: 1'b0, dsel: DSEL_I,
                  cond: COND_ALWAYS, test: TEST_NONE, iop: IOP_KEEP, next: STEP_IDLE};
            case (upc)
                STEP_IDLE:
                begin
                    w.accept = 1'b1;
                    w.cond   = COND_IN_BEAT;
                    w.next   = STEP_ENTRY;
                end
                STEP_ENTRY:
                begin
                    w.test = TEST_ENTRY;
                    w.next = STEP_MOD3;
                end
                STEP_MOD3:
                begin
                    w.test = TEST_MOD3;
                    w.iop  = IOP_INIT;
                    w.next = STEP_DIV_I;
                end
                STEP_DIV_I:
                begin
                    w.start_div = 1'b1;
                    w.dsel      = DSEL_I;
                    w.next      = STEP_WAIT_I;
                end
                STEP_WAIT_I:
                begin
                    w.cond = COND_DIV_DONE;
                    w.test = TEST_BOUND_REM;
                    w.next = STEP_DIV_I2;
                end
                STEP_DIV_I2:
                begin
                    w.start_div = 1'b1;
                    w.dsel      = DSEL_I_PLUS2;
                    w.next      = STEP_WAIT_I2;
                end
                STEP_WAIT_I2:
                begin
                    w.cond = COND_DIV_DONE;
                    w.test = TEST_REM;
                    w.iop  = IOP_STEP;
                    w.next = STEP_DIV_I;
                end
                STEP_EMIT:
                begin
                    w.emit = 1'b1;
                    w.cond = COND_OUT_BEAT;
                    w.next = STEP_IDLE;
                end
                default:
                begin
                    w.next = STEP_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

// ===== src/ptd_divider.sv =====
`include "prime_trial_division_unit_defines.svh"

module ptd_divider
    import ptd_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder,
    output logic         done
);

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          done_reg, done_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  div_reg, div_next;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    // restoring step: one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = (trial >= {1'b0, div_reg});

    always_comb
    begin
        count_next = count_reg;
        done_next  = done_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start)
        begin
            count_next = CW'(W);
            done_next  = 1'b0;
            quo_next   = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - CW'(1);
            quo_next   = {quo_reg[W-2:0], ge};
            rem_next   = ge ? diff[W-1:0] : trial[W-1:0];
            if (count_reg == CW'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

    `PTD_ASSERT_IMPLIES(a_rem_below_divisor, $rose(done_reg), rem_reg < div_reg, "remainder not below divisor")
    `PTD_ASSERT_NEXT(a_start_clears_done, start, !done_reg && count_reg == CW'(W), "start did not restart divider")

endmodule

// ===== src/prime_trial_division_unit.sv =====
// Negatives, 0..3 and even values are settled in the entry step and go straight to emit.
// Multiples of 3 are settled in the mod-3 step; others then divide by each 6k+/-1 pair in turn.
// Worst case at 32 bits is about 7700 pairs.
// Throughput: one candidate at a time; set by the single shared radix-2 divider.
// Reset: rst_n async, active low; sequencer returns to idle, no clearing pass.
`include "prime_trial_division_unit_defines.svh"

module prime_trial_division_unit
    import ptd_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] candidate,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          is_prime
);

    localparam int W = VALUE_WIDTH;

    // Mod-3 by digit folding: 4^k = 1 mod 3, so any split at an even bit
    // position keeps the residue. First half folds 64 -> 18 bits.
    function automatic logic [17:0] fold_hi(input logic [W-1:0] v);
        logic [63:0] x;
        logic [32:0] a;
        begin
            x = 64'(v);
            a = {1'b0, x[63:32]} + {1'b0, x[31:0]};
            return {1'b0, a[32:16]} + {2'b00, a[15:0]};
        end
    endfunction

    // Second half: 18 -> 3 bits, residue zero when the sum is 0 or 3.
    function automatic logic mod3_zero(input logic [17:0] f);
        logic [10:0] b;
        logic [7:0]  c;
        logic [4:0]  d;
        logic [3:0]  e;
        logic [2:0]  g;
        begin
            b = {1'b0, f[17:8]} + {3'b000, f[7:0]};
            c = {1'b0, b[10:4]} + {4'b0000, b[3:0]};
            d = {1'b0, c[7:4]} + {1'b0, c[3:0]};
            e = {1'b0, d[4:2]} + {2'b00, d[1:0]};
            g = {1'b0, e[3:2]} + {1'b0, e[1:0]};
            return (g == 3'd0) || (g == 3'd3);
        end
    endfunction

    // Microsequencer: upc_reg addresses the control store in ptd_pkg.
    upc_t      upc_reg, upc_next;
    ctl_word_t ctl;

    // Datapath registers. The loop index i stays 5 mod 6 and never exceeds
    // sqrt(candidate)+6, so W bits hold i and i+2 with room to spare.
    logic [W-1:0] cand_reg;
    logic [W-1:0] i_reg, i_next;
    logic         result_reg, result_next;
    // partial mod-3 fold of cand_reg, valid from the step after entry
    logic [17:0]  fold_reg, fold_next;

    logic         in_beat;
    logic         out_beat;
    logic         cond_ok;
    logic         finish;
    logic         finish_val;

    logic [W-1:0] div_divisor;
    logic [W-1:0] div_quo;
    logic [W-1:0] div_rem;
    logic         div_done;

    assign ctl       = ptd_ucode(upc_reg);
    assign in_stall  = !ctl.accept;
    assign out_valid = ctl.emit;
    assign is_prime  = result_reg;
    assign in_beat   = in_valid && !in_stall;
    assign out_beat  = out_valid && !out_stall;
    assign fold_next = fold_hi(cand_reg);

    // divisor mux for the shared divider
    always_comb
    begin
        case (ctl.dsel)
            DSEL_I:       div_divisor = i_reg;
            DSEL_I_PLUS2: div_divisor = i_reg + W'(PAIR_OFFSET);
            default:      div_divisor = i_reg;
        endcase
    end

    ptd_divider #(
        .W (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctl.start_div),
        .dividend  (cand_reg),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    always_comb
    begin
        case (ctl.cond)
            COND_ALWAYS:   cond_ok = 1'b1;
            COND_IN_BEAT:  cond_ok = in_beat;
            COND_OUT_BEAT: cond_ok = out_beat;
            COND_DIV_DONE: cond_ok = div_done;
            default:       cond_ok = 1'b0;
        endcase
    end

    // Step tests. A settled answer overrides the control word's next address.
    always_comb
    begin
        upc_next    = upc_reg;
        i_next      = i_reg;
        result_next = result_reg;
        finish      = 1'b0;
        finish_val  = 1'b0;
        if (cond_ok)
        begin
            upc_next = ctl.next;
            case (ctl.test)
                TEST_ENTRY:
                begin
                    // sign set, 0 or 1: not prime; 2 or 3: prime; even: not prime
                    if (cand_reg[W-1] || cand_reg[W-1:1] == '0)
                    begin
                        finish = 1'b1;
                    end
                    else if (cand_reg[W-1:2] == '0)
                    begin
                        finish     = 1'b1;
                        finish_val = 1'b1;
                    end
                    else if (!cand_reg[0])
                    begin
                        finish = 1'b1;
                    end
                end
                TEST_MOD3:
                begin
                    if (mod3_zero(fold_reg))
                    begin
                        finish = 1'b1;
                    end
                end
                TEST_REM:
                begin
                    if (div_rem == '0)
                    begin
                        finish = 1'b1;
                    end
                end
                TEST_BOUND_REM:
                begin
                    // i > v/i means i*i > v: no divisor left, prime
                    if (i_reg > div_quo)
                    begin
                        finish     = 1'b1;
                        finish_val = 1'b1;
                    end
                    else if (div_rem == '0)
                    begin
                        finish = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            case (ctl.iop)
                IOP_INIT: i_next = W'(FIRST_DIVISOR);
                IOP_STEP: i_next = i_reg + W'(DIVISOR_STEP);
                default:  i_next = i_reg;
            endcase
            if (finish)
            begin
                upc_next    = STEP_EMIT;
                result_next = finish_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            cand_reg <= $unsigned(candidate);
        end
        i_reg      <= i_next;
        result_reg <= result_next;
        fold_reg   <= fold_next;
    end

    `PTD_ASSERT_NEXT(a_beat_starts_entry, in_beat, upc_reg == STEP_ENTRY, "input beat did not start entry step")
    `PTD_ASSERT_IMPLIES(a_divisor_odd, upc_reg == STEP_DIV_I || upc_reg == STEP_DIV_I2, i_reg[0], "trial divisor is even")
    `PTD_ASSERT_IMPLIES(a_prime_odd_or_two, out_valid && is_prime, cand_reg[0] || cand_reg == W'(2), "even value reported prime")

endmodule
